/* rtl/tcha_pkg.sv */
// tcha_pkg: shared types, constants and the microcode program of the tile corner
// height averager. No dependencies; used by every other file under rtl/.
package tcha_pkg;

    // default grid limits, handed to the top level parameters
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    // field widths
    localparam int GRID_W    = 7;
    localparam int ROW_W     = 6;
    localparam int COL_W     = 6;
    localparam int HGT_W     = 8;
    localparam int VTX_W     = 7;
    localparam int QH_W      = 16;
    localparam int TILE_W    = 9;
    localparam int SUM_W     = 10;
    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

    // item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_BAKE = 1'b1;

    // divide by three: q = (x * 683) >> 11, exact for x below 2048
    localparam int          DIV3_MUL   = 683;
    localparam int          DIV3_SHIFT = 11;
    localparam logic [7:0]  DIV3_FRAC1 = 8'd85;
    localparam logic [7:0]  DIV3_FRAC2 = 8'd170;

    localparam logic [1:0] CORNER_LAST = 2'd3;

    // program counter and entry points
    localparam int               PC_W    = 4;
    localparam logic [PC_W-1:0]  PC_LOAD = 4'd0;
    localparam logic [PC_W-1:0]  PC_BAKE = 4'd1;
    localparam logic [PC_W-1:0]  PC_ERR  = 4'd12;

    // tile offset relative to the item's tile
    typedef enum logic [1:0] {
        OFF_M1 = 2'd0,
        OFF_Z  = 2'd1,
        OFF_P1 = 2'd2
    } t_off;

    // one control word
    typedef struct packed {
        logic       wr;      // write the item's tile
        logic       rd;      // read the tile at (dr, dc)
        t_off       dr;
        t_off       dc;
        logic       clr;     // clear corner accumulators
        logic       emit;    // emit corner vertex
        logic [1:0] corner;
        logic       err;     // emit range error beat
        logic       jmp;     // go to error step if tile outside the grid
        logic       done;    // last step of the program
    } t_uop;

    // microcode rom
    function automatic t_uop micro_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        u    = '0;
        u.dr = OFF_Z;
        u.dc = OFF_Z;
        case (pc)
            PC_LOAD: begin
                u.wr   = 1'b1;
                u.done = 1'b1;
            end
            PC_BAKE: begin
                u.clr = 1'b1;
                u.jmp = 1'b1;
                u.rd  = 1'b1;
                u.dr  = OFF_M1;
                u.dc  = OFF_M1;
            end
            4'd2: begin
                u.rd = 1'b1;
                u.dr = OFF_M1;
            end
            4'd3: begin
                u.rd = 1'b1;
                u.dc = OFF_M1;
            end
            4'd4: begin
                u.rd = 1'b1;
            end
            4'd5: begin
                u.rd = 1'b1;
                u.dr = OFF_M1;
                u.dc = OFF_P1;
            end
            4'd6: begin
                u.rd     = 1'b1;
                u.dc     = OFF_P1;
                u.emit   = 1'b1;
                u.corner = 2'd0;
            end
            4'd7: begin
                u.rd = 1'b1;
                u.dr = OFF_P1;
                u.dc = OFF_M1;
            end
            4'd8: begin
                u.rd     = 1'b1;
                u.dr     = OFF_P1;
                u.emit   = 1'b1;
                u.corner = 2'd1;
            end
            4'd9: begin
                u.rd = 1'b1;
                u.dr = OFF_P1;
                u.dc = OFF_P1;
            end
            4'd10: begin
                u.emit   = 1'b1;
                u.corner = 2'd2;
            end
            4'd11: begin
                u.emit   = 1'b1;
                u.corner = CORNER_LAST;
                u.done   = 1'b1;
            end
            PC_ERR: begin
                u.err  = 1'b1;
                u.done = 1'b1;
            end
            default: begin
                u.done = 1'b1;
            end
        endcase
        return u;
    endfunction

endpackage

/* rtl/tile_corner_height_averager.sv */
// tile_corner_height_averager: top level, configuration registers and the
// sequencer, datapath and tile memory. Depends on tcha_pkg, tcha_seq, tcha_dp, tcha_store.
//
//  channel  | handshake                         | payload
//  ---------+-----------------------------------+----------------------------------------
//  item in  | start, busy (taken: start & !busy) | i_func i_tile_row i_tile_col
//           |                                   | i_tile_height i_merge_all
//  result   | o_valid, one cycle per beat       | o_vertex_row o_vertex_col o_vertex_height
//           |                                   | o_last_vertex o_range_error
//  config   | i_cfg_valid, o_cfg_ready (always) | i_cfg_index i_cfg_data
//
// A load keeps busy high for 1 cycle; a bake inside the grid stays busy through nine tile
// reads through the single memory port, then two steps for the read latency and the
// last two corners. A bake outside the grid gives one error beat.
// Each beat comes out in the cycle after its microcode step, so the last one may
// coincide with the next item being taken; the receiver cannot stall the beats.
// The tile memory is not cleared by the synchronous reset; the grid returns to 64 x 64.
module tile_corner_height_averager #(
    parameter int MAX_ROWS = tcha_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = tcha_pkg::MAX_COLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item in
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_func,
    input  logic [tcha_pkg::ROW_W-1:0]     i_tile_row,
    input  logic [tcha_pkg::COL_W-1:0]     i_tile_col,
    input  logic [tcha_pkg::HGT_W-1:0]     i_tile_height,
    input  logic                           i_merge_all,
    // result
    output logic                           o_valid,
    output logic [tcha_pkg::VTX_W-1:0]     o_vertex_row,
    output logic [tcha_pkg::VTX_W-1:0]     o_vertex_col,
    output logic [tcha_pkg::QH_W-1:0]      o_vertex_height,
    output logic                           o_last_vertex,
    output logic                           o_range_error,
    // configuration
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tcha_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tcha_pkg::GRID_W-1:0]    i_cfg_data
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);

    // grid registers
    logic [tcha_pkg::GRID_W-1:0] r_grid_rows;
    logic [tcha_pkg::GRID_W-1:0] r_grid_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= tcha_pkg::GRID_RESET;
            r_grid_cols <= tcha_pkg::GRID_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tcha_pkg::REG_GRID_ROWS: r_grid_rows <= i_cfg_data;
                tcha_pkg::REG_GRID_COLS: r_grid_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    logic                        take;
    logic                        tile_in;
    tcha_pkg::t_uop              uop;
    logic                        we;
    logic                        re;
    logic [ADDR_W-1:0]           addr;
    logic [tcha_pkg::TILE_W-1:0] wdata;
    logic [tcha_pkg::TILE_W-1:0] rdata;

    assign take = start && !busy;

    tcha_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_func   (i_func),
        .i_inside (tile_in),
        .o_busy   (busy),
        .o_uop    (uop)
    );

    tcha_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .ADDR_W   (ADDR_W)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_tile_row      (i_tile_row),
        .i_tile_col      (i_tile_col),
        .i_tile_height   (i_tile_height),
        .i_merge_all     (i_merge_all),
        .i_grid_rows     (r_grid_rows),
        .i_grid_cols     (r_grid_cols),
        .i_uop           (uop),
        .o_inside        (tile_in),
        .o_we            (we),
        .o_re            (re),
        .o_addr          (addr),
        .o_wdata         (wdata),
        .i_rdata         (rdata),
        .o_valid         (o_valid),
        .o_vertex_row    (o_vertex_row),
        .o_vertex_col    (o_vertex_col),
        .o_vertex_height (o_vertex_height),
        .o_last_vertex   (o_last_vertex),
        .o_range_error   (o_range_error)
    );

    tcha_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_re    (re),
        .i_addr  (addr),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

endmodule

/* rtl/tcha_store.sv */
// tcha_store: single port tile memory, one write or one read per cycle,
// registered read data. Depends on tcha_pkg for the default size and word width.
module tcha_store #(
    parameter int DEPTH  = tcha_pkg::MAX_ROWS_DEF * tcha_pkg::MAX_COLS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic                        i_re,
    input  logic [ADDR_W-1:0]           i_addr,
    input  logic [tcha_pkg::TILE_W-1:0] i_wdata,
    output logic [tcha_pkg::TILE_W-1:0] o_rdata
);

    logic [tcha_pkg::TILE_W-1:0] mem [DEPTH];
    logic [tcha_pkg::TILE_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/tcha_seq.sv */
// tcha_seq: microcode sequencer, step counter over the program in tcha_pkg
// with the conditional jump to the range error step. Depends on tcha_pkg.
module tcha_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  logic           i_func,
    input  logic           i_inside,
    output logic           o_busy,
    output tcha_pkg::t_uop o_uop
);

    logic                      r_busy;
    logic [tcha_pkg::PC_W-1:0] r_pc;
    logic                      n_busy;
    logic [tcha_pkg::PC_W-1:0] n_pc;
    tcha_pkg::t_uop            uop;

    // current control word, no operation while idle
    always_comb begin
        uop = tcha_pkg::micro_rom(r_pc);
        if (!r_busy) begin
            uop = '0;
        end
    end

    // next step
    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (i_take) begin
            n_busy = 1'b1;
            n_pc   = (i_func == tcha_pkg::FUNC_BAKE) ? tcha_pkg::PC_BAKE : tcha_pkg::PC_LOAD;
        end else if (r_busy) begin
            if (uop.jmp && !i_inside) begin
                n_pc = tcha_pkg::PC_ERR;
            end else if (uop.done) begin
                n_busy = 1'b0;
            end else begin
                n_pc = r_pc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= tcha_pkg::PC_LOAD;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    assign o_busy = r_busy;
    assign o_uop  = uop;

endmodule

/* rtl/tcha_dp.sv */
// tcha_dp: datapath of the averager: item latch, address and bounds logic,
// corner accumulators, small divider and result register. Depends on tcha_pkg.
module tcha_dp #(
    parameter int MAX_ROWS = tcha_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = tcha_pkg::MAX_COLS_DEF,
    parameter int ADDR_W   = $clog2(MAX_ROWS * MAX_COLS)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  logic [tcha_pkg::ROW_W-1:0]  i_tile_row,
    input  logic [tcha_pkg::COL_W-1:0]  i_tile_col,
    input  logic [tcha_pkg::HGT_W-1:0]  i_tile_height,
    input  logic                        i_merge_all,
    input  logic [tcha_pkg::GRID_W-1:0] i_grid_rows,
    input  logic [tcha_pkg::GRID_W-1:0] i_grid_cols,
    input  tcha_pkg::t_uop              i_uop,
    output logic                        o_inside,
    // tile memory side
    output logic                        o_we,
    output logic                        o_re,
    output logic [ADDR_W-1:0]           o_addr,
    output logic [tcha_pkg::TILE_W-1:0] o_wdata,
    input  logic [tcha_pkg::TILE_W-1:0] i_rdata,
    // result
    output logic                        o_valid,
    output logic [tcha_pkg::VTX_W-1:0]  o_vertex_row,
    output logic [tcha_pkg::VTX_W-1:0]  o_vertex_col,
    output logic [tcha_pkg::QH_W-1:0]   o_vertex_height,
    output logic                        o_last_vertex,
    output logic                        o_range_error
);

    // item latch
    logic [tcha_pkg::ROW_W-1:0] r_row;
    logic [tcha_pkg::COL_W-1:0] r_col;
    logic [tcha_pkg::HGT_W-1:0] r_height;
    logic                       r_merge;

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_row    <= i_tile_row;
            r_col    <= i_tile_col;
            r_height <= i_tile_height;
            r_merge  <= i_merge_all;
        end
    end

    // item tile inside the grid (register above limit acts as the limit)
    assign o_inside = (32'(r_row) < 32'(i_grid_rows)) && (32'(r_row) < MAX_ROWS) &&
                      (32'(r_col) < 32'(i_grid_cols)) && (32'(r_col) < MAX_COLS);

    // neighbor tile position and bounds
    logic [7:0] tr;
    logic [7:0] tc;
    logic       in_grid;

    always_comb begin
        tr      = 8'(r_row) + 8'(i_uop.dr) - 8'd1;
        tc      = 8'(r_col) + 8'(i_uop.dc) - 8'd1;
        in_grid = !tr[7] && !tc[7] &&
                  (32'(tr) < 32'(i_grid_rows)) && (32'(tr) < MAX_ROWS) &&
                  (32'(tc) < 32'(i_grid_cols)) && (32'(tc) < MAX_COLS);
    end

    assign o_addr  = ADDR_W'(32'(tr) * MAX_COLS + 32'(tc));
    assign o_we    = i_uop.wr && o_inside;
    assign o_re    = i_uop.rd && in_grid;
    assign o_wdata = {r_merge, r_height};

    // read beat tracking, data arrives in the cycle after the read
    logic           r_rd_vld;
    tcha_pkg::t_off r_rd_dr;
    tcha_pkg::t_off r_rd_dc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= o_re;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_dr <= i_uop.dr;
        r_rd_dc <= i_uop.dc;
    end

    // which corners the returned tile touches
    logic [3:0] hit;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            hit[k] = ((k / 2 == 0) ? (r_rd_dr != tcha_pkg::OFF_P1)
                                   : (r_rd_dr != tcha_pkg::OFF_M1)) &&
                     ((k % 2 == 0) ? (r_rd_dc != tcha_pkg::OFF_P1)
                                   : (r_rd_dc != tcha_pkg::OFF_M1));
        end
    end

    // corner accumulators over merged tiles
    logic [tcha_pkg::SUM_W-1:0]  r_sum [4];
    logic [tcha_pkg::CNT_W-1:0]  r_cnt [4];
    logic [tcha_pkg::TILE_W-1:0] r_self;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (i_uop.clr) begin
                r_sum[k] <= '0;
                r_cnt[k] <= '0;
            end else if (r_rd_vld && i_rdata[tcha_pkg::TILE_W-1] && hit[k]) begin
                r_sum[k] <= r_sum[k] + tcha_pkg::SUM_W'(i_rdata[tcha_pkg::HGT_W-1:0]);
                r_cnt[k] <= r_cnt[k] + 1'b1;
            end
        end
    end

    // own tile captured when the center read returns
    always_ff @(posedge i_clk) begin
        if (r_rd_vld && r_rd_dr == tcha_pkg::OFF_Z && r_rd_dc == tcha_pkg::OFF_Z) begin
            r_self <= i_rdata;
        end
    end

    // Q8.8 mean of the selected corner
    logic [tcha_pkg::SUM_W-1:0]        sel_sum;
    logic [tcha_pkg::CNT_W-1:0]        sel_cnt;
    logic [2*tcha_pkg::SUM_W:0]        prod3;
    logic [tcha_pkg::SUM_W-1:0]        q3;
    logic [tcha_pkg::SUM_W-1:0]        rem_full;
    logic [7:0]                        frac3;
    logic [tcha_pkg::QH_W-1:0]         mean;
    logic [tcha_pkg::QH_W-1:0]         height;

    always_comb begin
        sel_sum  = r_sum[i_uop.corner];
        sel_cnt  = r_cnt[i_uop.corner];
        prod3    = (2*tcha_pkg::SUM_W+1)'(sel_sum) *
                   (2*tcha_pkg::SUM_W+1)'(tcha_pkg::DIV3_MUL);
        q3       = prod3[tcha_pkg::DIV3_SHIFT +: tcha_pkg::SUM_W];
        rem_full = sel_sum - tcha_pkg::SUM_W'(q3 * 3);
        case (rem_full[1:0])
            2'd1:    frac3 = tcha_pkg::DIV3_FRAC1;
            2'd2:    frac3 = tcha_pkg::DIV3_FRAC2;
            default: frac3 = 8'd0;
        endcase
        case (sel_cnt)
            3'd1:    mean = tcha_pkg::QH_W'({sel_sum, 8'b0});
            3'd2:    mean = tcha_pkg::QH_W'({sel_sum, 7'b0});
            3'd3:    mean = {q3[7:0], frac3};
            3'd4:    mean = tcha_pkg::QH_W'({sel_sum, 6'b0});
            default: mean = '0;
        endcase
        if (r_self[tcha_pkg::TILE_W-1]) begin
            height = mean;
        end else begin
            height = {r_self[tcha_pkg::HGT_W-1:0], 8'b0};
        end
    end

    // result register
    logic                       r_valid;
    logic [tcha_pkg::VTX_W-1:0] r_vertex_row;
    logic [tcha_pkg::VTX_W-1:0] r_vertex_col;
    logic [tcha_pkg::QH_W-1:0]  r_vertex_height;
    logic                       r_last_vertex;
    logic                       r_range_error;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_uop.emit || i_uop.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_uop.err) begin
            r_vertex_row    <= '0;
            r_vertex_col    <= '0;
            r_vertex_height <= '0;
            r_last_vertex   <= 1'b1;
            r_range_error   <= 1'b1;
        end else if (i_uop.emit) begin
            r_vertex_row    <= tcha_pkg::VTX_W'(r_row) + tcha_pkg::VTX_W'(i_uop.corner[1]);
            r_vertex_col    <= tcha_pkg::VTX_W'(r_col) + tcha_pkg::VTX_W'(i_uop.corner[0]);
            r_vertex_height <= height;
            r_last_vertex   <= (i_uop.corner == tcha_pkg::CORNER_LAST);
            r_range_error   <= 1'b0;
        end
    end

    assign o_valid         = r_valid;
    assign o_vertex_row    = r_vertex_row;
    assign o_vertex_col    = r_vertex_col;
    assign o_vertex_height = r_vertex_height;
    assign o_last_vertex   = r_last_vertex;
    assign o_range_error   = r_range_error;

endmodule

/* rtl/tcha_chk.sv */
// tcha_chk: port level checks of tile_corner_height_averager and its bind.
// Depends on tcha_pkg and the top level's ports.
module tcha_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       i_func,
    input logic                       o_valid,
    input logic [tcha_pkg::QH_W-1:0]  o_vertex_height,
    input logic [tcha_pkg::VTX_W-1:0] o_vertex_row,
    input logic                       o_last_vertex,
    input logic                       o_range_error
);

    // a bake keeps the block busy after it is taken
    a_bake_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_func == tcha_pkg::FUNC_BAKE |=> busy)
        else $error("bake taken but block not busy");

    // no beat directly after an item is taken
    a_no_early_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> !o_valid)
        else $error("beat right after item taken");

    // error beat is the last one and carries zeros
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_range_error |-> o_last_vertex && o_vertex_height == '0 &&
                                     o_vertex_row == '0)
        else $error("malformed range error beat");

    // nothing follows the last beat of an item
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_vertex |=> !o_valid)
        else $error("beat after last vertex");

endmodule

bind tile_corner_height_averager tcha_chk u_tcha_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_func          (i_func),
    .o_valid         (o_valid),
    .o_vertex_height (o_vertex_height),
    .o_vertex_row    (o_vertex_row),
    .o_last_vertex   (o_last_vertex),
    .o_range_error   (o_range_error)
);

/* bench/tb_tile_corner_height_averager.sv */
// tb_tile_corner_height_averager: self-checking bench for the tile corner height averager,
// a directed table followed by random load and bake sequences, checked by a local predictor.
// Depends on rtl/tcha_pkg.sv and rtl/tile_corner_height_averager.sv.
module tb_tile_corner_height_averager;

    localparam int N_ROWS     = tcha_pkg::MAX_ROWS_DEF;
    localparam int N_COLS     = tcha_pkg::MAX_COLS_DEF;
    localparam int N_RANDOM   = 210;
    localparam int SETTLE     = 16;
    localparam int N_DIRECTED = 25;

    // short names for the table
    localparam logic                           LD = tcha_pkg::FUNC_LOAD;
    localparam logic                           BK = tcha_pkg::FUNC_BAKE;
    localparam logic [tcha_pkg::CFG_IDX_W-1:0] GR = tcha_pkg::REG_GRID_ROWS;
    localparam logic [tcha_pkg::CFG_IDX_W-1:0] GC = tcha_pkg::REG_GRID_COLS;

    // one input beat
    typedef struct packed {
        logic                       func;
        logic [tcha_pkg::ROW_W-1:0] row;
        logic [tcha_pkg::COL_W-1:0] col;
        logic [tcha_pkg::HGT_W-1:0] height;
        logic                       merge;
    } t_tile_cmd;

    // one result beat
    typedef struct packed {
        logic [tcha_pkg::VTX_W-1:0] vrow;
        logic [tcha_pkg::VTX_W-1:0] vcol;
        logic [tcha_pkg::QH_W-1:0]  height;
        logic                       last;
        logic                       err;
    } t_vertex;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } t_dir_kind;

    // directed step: an item or a register write, with an optional hand-typed answer
    typedef struct packed {
        t_dir_kind                      kind;
        t_tile_cmd                      cmd;
        logic [tcha_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [tcha_pkg::GRID_W-1:0]    reg_val;
        logic                           typed;
        logic [tcha_pkg::QH_W-1:0]      typed_h;
        logic                           typed_err;
    } t_dir_row;

    // kind, {func, row, col, height, merge}, register, value, typed, height, error
    localparam t_dir_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{ROW_ITEM, '{LD,  0,  0, 255, 0}, GR,   0, 0, 16'h0000, 0},
        '{ROW_ITEM, '{LD,  0,  1,   1, 1}, GR,   0, 0, 16'h0000, 0},
        '{ROW_ITEM, '{LD,  1,  0, 128, 1}, GR,   0, 0, 16'h0000, 0},
        '{ROW_ITEM, '{LD,  1,  1, 254, 1}, GR,   0, 0, 16'h0000, 0},
        '{ROW_ITEM, '{BK,  0,  0,   0, 0}, GR,   0, 1, 16'hFF00, 0},
        '{ROW_ITEM, '{LD,  0,  0, 255, 1}, GR,   0, 0, 16'h0000, 0},
        '{ROW_ITEM, '{BK,  0,  0,   0, 0}, GR,   0, 0, 16'h0000, 0},
        '{ROW_ITEM, '{LD,  0,  2,   7, 0}, GR,   0, 0, 16'h0000, 0},
        '{ROW_ITEM, '{LD,  1,  2, 100, 1}, GR,   0, 0, 16'h0000, 0},
        '{ROW_ITEM, '{BK,  0,  1, 255, 1}, GR,   0, 0, 16'h0000, 0},
        '{ROW_ITEM, '{LD, 63, 63,   0, 1}, GR,   0, 0, 16'h0000, 0},
        '{ROW_ITEM, '{LD, 62, 62, 255, 1}, GR,   0, 0, 16'h0000, 0},
        '{ROW_ITEM, '{LD, 62, 63, 200, 0}, GR,   0, 0, 16'h0000, 0},
        '{ROW_ITEM, '{LD, 63, 62,  99, 1}, GR,   0, 0, 16'h0000, 0},
        '{ROW_ITEM, '{BK, 63, 63,   0, 0}, GR,   0, 0, 16'h0000, 0},
        '{ROW_CFG,  '{LD,  0,  0,   0, 0}, GR,   0, 0, 16'h0000, 0},
        '{ROW_ITEM, '{LD,  5,  5,  33, 1}, GR,   0, 0, 16'h0000, 0},
        '{ROW_ITEM, '{BK,  0,  0,   0, 0}, GR,   0, 1, 16'h0000, 1},
        '{ROW_CFG,  '{LD,  0,  0,   0, 0}, GR, 127, 0, 16'h0000, 0},
        '{ROW_CFG,  '{LD,  0,  0,   0, 0}, GC,   1, 0, 16'h0000, 0},
        '{ROW_ITEM, '{BK,  0,  1,   0, 0}, GR,   0, 1, 16'h0000, 1},
        '{ROW_ITEM, '{LD, 40,  1,   9, 1}, GR,   0, 0, 16'h0000, 0},
        '{ROW_ITEM, '{BK,  0,  0,   0, 0}, GR,   0, 0, 16'h0000, 0},
        '{ROW_CFG,  '{LD,  0,  0,   0, 0}, GC,  64, 0, 16'h0000, 0},
        '{ROW_CFG,  '{LD,  0,  0,   0, 0}, GR,  64, 0, 16'h0000, 0}
    };

    // dut ports
    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           start         = 1'b0;
    logic                           i_func        = tcha_pkg::FUNC_LOAD;
    logic [tcha_pkg::ROW_W-1:0]     i_tile_row    = '0;
    logic [tcha_pkg::COL_W-1:0]     i_tile_col    = '0;
    logic [tcha_pkg::HGT_W-1:0]     i_tile_height = '0;
    logic                           i_merge_all   = 1'b0;
    logic                           i_cfg_valid   = 1'b0;
    logic [tcha_pkg::CFG_IDX_W-1:0] i_cfg_index   = tcha_pkg::REG_GRID_ROWS;
    logic [tcha_pkg::GRID_W-1:0]    i_cfg_data    = '0;
    logic                           busy;
    logic                           o_valid;
    logic [tcha_pkg::VTX_W-1:0]     o_vertex_row;
    logic [tcha_pkg::VTX_W-1:0]     o_vertex_col;
    logic [tcha_pkg::QH_W-1:0]      o_vertex_height;
    logic                           o_last_vertex;
    logic                           o_range_error;
    logic                           o_cfg_ready;

    // predictor state
    logic [tcha_pkg::TILE_W-1:0] tile_mem    [N_ROWS * N_COLS];
    bit                          tile_loaded [N_ROWS * N_COLS];
    logic [tcha_pkg::GRID_W-1:0] grid_rows_q = tcha_pkg::GRID_RESET;
    logic [tcha_pkg::GRID_W-1:0] grid_cols_q = tcha_pkg::GRID_RESET;

    t_vertex pending_vertices [$];
    int      fault_count = 0;
    int      items_done  = 0;
    bit      no_idle     = 1'b0;

    tile_corner_height_averager u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_tile_row      (i_tile_row),
        .i_tile_col      (i_tile_col),
        .i_tile_height   (i_tile_height),
        .i_merge_all     (i_merge_all),
        .o_valid         (o_valid),
        .o_vertex_row    (o_vertex_row),
        .o_vertex_col    (o_vertex_col),
        .o_vertex_height (o_vertex_height),
        .o_last_vertex   (o_last_vertex),
        .o_range_error   (o_range_error),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // clock, period 8
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // grid size in use, clamped to the store
    function automatic int rows_in_grid();
        return (grid_rows_q > N_ROWS) ? N_ROWS : int'(grid_rows_q);
    endfunction

    function automatic int cols_in_grid();
        return (grid_cols_q > N_COLS) ? N_COLS : int'(grid_cols_q);
    endfunction

    function automatic bit tile_inside(input int r, input int c);
        return r >= 0 && c >= 0 && r < rows_in_grid() && c < cols_in_grid();
    endfunction

    // every in-grid tile of the 3x3 around (r, c) has been loaded
    function automatic bit nbhd_ready(input int r, input int c);
        bit ok;
        ok = 1'b1;
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
                if (tile_inside(r + dr, c + dc) && !tile_loaded[(r + dr) * N_COLS + c + dc])
                    ok = 1'b0;
        return ok;
    endfunction

    // truncated q8.8 mean of the merged tiles touching corner (vr, vc)
    function automatic logic [tcha_pkg::QH_W-1:0] corner_mean(input int vr, input int vc);
        int                          sum;
        int                          cnt;
        logic [tcha_pkg::TILE_W-1:0] t;
        sum = 0;
        cnt = 0;
        for (int dr = -1; dr <= 0; dr++)
            for (int dc = -1; dc <= 0; dc++)
                if (tile_inside(vr + dr, vc + dc)) begin
                    t = tile_mem[(vr + dr) * N_COLS + vc + dc];
                    if (t[tcha_pkg::TILE_W-1]) begin
                        sum += int'(t[tcha_pkg::HGT_W-1:0]);
                        cnt++;
                    end
                end
        return (cnt == 0) ? '0 : tcha_pkg::QH_W'((sum * 256) / cnt);
    endfunction

    // update the tile store or queue the corner beats of one accepted item
    task automatic predict_corners(input t_tile_cmd cmd);
        int                          r;
        int                          c;
        logic [tcha_pkg::TILE_W-1:0] self_t;
        t_vertex                     v;
        r = int'(cmd.row);
        c = int'(cmd.col);
        if (cmd.func == tcha_pkg::FUNC_LOAD) begin
            if (tile_inside(r, c)) begin
                tile_mem[r * N_COLS + c]    = {cmd.merge, cmd.height};
                tile_loaded[r * N_COLS + c] = 1'b1;
            end
            return;
        end
        if (!tile_inside(r, c)) begin
            v      = '0;
            v.last = 1'b1;
            v.err  = 1'b1;
            pending_vertices.push_back(v);
            return;
        end
        self_t = tile_mem[r * N_COLS + c];
        for (int k = 0; k < 4; k++) begin
            v.vrow   = tcha_pkg::VTX_W'(r + k / 2);
            v.vcol   = tcha_pkg::VTX_W'(c + k % 2);
            v.height = self_t[tcha_pkg::TILE_W-1] ? corner_mean(r + k / 2, c + k % 2)
                                                  : {self_t[tcha_pkg::HGT_W-1:0], 8'h00};
            v.last   = (k == 3);
            v.err    = 1'b0;
            pending_vertices.push_back(v);
        end
    endtask

    function automatic t_tile_cmd make_cmd(input logic func, input int r, input int c,
                                           input int h, input int m);
        t_tile_cmd cmd;
        cmd.func   = func;
        cmd.row    = tcha_pkg::ROW_W'(r);
        cmd.col    = tcha_pkg::COL_W'(c);
        cmd.height = tcha_pkg::HGT_W'(h);
        cmd.merge  = m[0];
        return cmd;
    endfunction

    function automatic int rand_height();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 255;
            default: return int'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [tcha_pkg::GRID_W-1:0] pick_grid_dim();
        case ($urandom_range(0, 11))
            0:         return '0;
            1:         return tcha_pkg::GRID_W'(1);
            2:         return tcha_pkg::GRID_W'(2);
            3:         return tcha_pkg::GRID_RESET;
            4:         return tcha_pkg::GRID_W'($urandom_range(65, 127));
            5, 6, 7:   return tcha_pkg::GRID_W'($urandom_range(1, 8));
            default:   return tcha_pkg::GRID_W'($urandom_range(1, 64));
        endcase
    endfunction

    // drive one item after a random gap, wait until taken, then record what it should give
    task automatic issue_cmd(input t_tile_cmd cmd, input bit typed,
                             input logic [tcha_pkg::QH_W-1:0] typed_h, input bit typed_err);
        int      gap;
        t_vertex v;
        gap = no_idle ? 0 : int'($urandom_range(0, 14));
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_func        <= cmd.func;
        i_tile_row    <= cmd.row;
        i_tile_col    <= cmd.col;
        i_tile_height <= cmd.height;
        i_merge_all   <= cmd.merge;
        do @(posedge i_clk); while (busy);
        items_done++;
        if (!typed) begin
            predict_corners(cmd);
        end else if (typed_err) begin
            v      = '0;
            v.last = 1'b1;
            v.err  = 1'b1;
            pending_vertices.push_back(v);
        end else begin
            for (int k = 0; k < 4; k++) begin
                v.vrow   = tcha_pkg::VTX_W'(int'(cmd.row) + k / 2);
                v.vcol   = tcha_pkg::VTX_W'(int'(cmd.col) + k % 2);
                v.height = typed_h;
                v.last   = (k == 3);
                v.err    = 1'b0;
                pending_vertices.push_back(v);
            end
        end
    endtask

    // register write, only once the block has drained
    task automatic write_grid_reg(input logic [tcha_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [tcha_pkg::GRID_W-1:0] val);
        start <= 1'b0;
        while (pending_vertices.size() != 0 || busy) @(posedge i_clk);
        repeat (SETTLE + $urandom_range(0, 14)) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == tcha_pkg::REG_GRID_ROWS)
            grid_rows_q = val;
        else
            grid_cols_q = val;
    endtask

    // result checker, one beat per strobe
    always @(posedge i_clk) begin
        t_vertex want;
        if (i_rst_n && o_valid) begin
            if (pending_vertices.size() == 0) begin
                $error("vertex beat with nothing expected: row %0d col %0d height %0d",
                       o_vertex_row, o_vertex_col, o_vertex_height);
                fault_count++;
            end else begin
                want = pending_vertices.pop_front();
                if (o_vertex_row !== want.vrow) begin
                    $error("vertex_row: expected %0d, got %0d", want.vrow, o_vertex_row);
                    fault_count++;
                end
                if (o_vertex_col !== want.vcol) begin
                    $error("vertex_col: expected %0d, got %0d", want.vcol, o_vertex_col);
                    fault_count++;
                end
                if (o_vertex_height !== want.height) begin
                    $error("vertex_height: expected %0d, got %0d", want.height,
                           o_vertex_height);
                    fault_count++;
                end
                if (o_last_vertex !== want.last) begin
                    $error("last_vertex: expected %0d, got %0d", want.last, o_last_vertex);
                    fault_count++;
                end
                if (o_range_error !== want.err) begin
                    $error("range_error: expected %0d, got %0d", want.err, o_range_error);
                    fault_count++;
                end
            end
        end
    end

    // stimulus
    initial begin
        t_dir_row d;
        int       phase;
        int       sel;
        int       r;
        int       c;
        int       nr;
        int       nc;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int i = 0; i < N_DIRECTED; i++) begin
            d = DIRECTED_ROWS[i];
            if (d.kind == ROW_CFG)
                write_grid_reg(d.reg_idx, d.reg_val);
            else
                issue_cmd(d.cmd, d.typed, d.typed_h, d.typed_err);
        end

        // random phases, each under its own grid size
        items_done = 0;
        phase      = 0;
        while (items_done < N_RANDOM) begin
            write_grid_reg(tcha_pkg::REG_GRID_ROWS,
                           (phase == 0) ? tcha_pkg::GRID_RESET :
                           (phase == 1) ? tcha_pkg::GRID_W'(1) : pick_grid_dim());
            write_grid_reg(tcha_pkg::REG_GRID_COLS,
                           (phase == 0) ? tcha_pkg::GRID_RESET :
                           (phase == 1) ? tcha_pkg::GRID_W'(1) : pick_grid_dim());
            no_idle = ($urandom_range(0, 3) == 0);
            nr      = rows_in_grid();
            nc      = cols_in_grid();
            for (int step = 0; step < 10 && items_done < N_RANDOM; step++) begin
                sel = int'($urandom_range(0, 9));
                if (nr != 0 && nc != 0 && sel < 7) begin
                    // well-formed: (re)load the neighborhood, then bake, edges favored
                    r = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? nr - 1 : 0)
                                                     : int'($urandom_range(0, nr - 1));
                    c = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? nc - 1 : 0)
                                                     : int'($urandom_range(0, nc - 1));
                    for (int dr = -1; dr <= 1; dr++)
                        for (int dc = -1; dc <= 1; dc++)
                            if (tile_inside(r + dr, c + dc) &&
                                (!tile_loaded[(r + dr) * N_COLS + c + dc] ||
                                 $urandom_range(0, 2) == 0))
                                issue_cmd(make_cmd(tcha_pkg::FUNC_LOAD, r + dr, c + dc,
                                                   rand_height(),
                                                   ($urandom_range(0, 3) != 0)),
                                          1'b0, '0, 1'b0);
                    issue_cmd(make_cmd(tcha_pkg::FUNC_BAKE, r, c,
                                       int'($urandom_range(0, 255)),
                                       int'($urandom_range(0, 1))), 1'b0, '0, 1'b0);
                end else if (sel == 7) begin
                    // stray load anywhere, maybe outside the grid
                    issue_cmd(make_cmd(tcha_pkg::FUNC_LOAD, int'($urandom_range(0, 63)),
                                       int'($urandom_range(0, 63)), rand_height(),
                                       int'($urandom_range(0, 1))), 1'b0, '0, 1'b0);
                end else begin
                    // stray bake: outside the grid, or inside over a loaded neighborhood
                    r = int'($urandom_range(0, 63));
                    c = int'($urandom_range(0, 63));
                    if (!tile_inside(r, c) || nbhd_ready(r, c))
                        issue_cmd(make_cmd(tcha_pkg::FUNC_BAKE, r, c,
                                           int'($urandom_range(0, 255)),
                                           int'($urandom_range(0, 1))), 1'b0, '0, 1'b0);
                end
            end
            phase++;
        end

        // drain
        start <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
rtl/tcha_pkg.sv
rtl/tcha_store.sv
rtl/tcha_seq.sv
rtl/tcha_dp.sv
rtl/tile_corner_height_averager.sv
rtl/tcha_chk.sv
bench/tb_tile_corner_height_averager.sv
